### design/lprr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lprr_pkg;

    // ring geometry
    parameter int RING_BYTES = 4096;
    parameter int MAX_RECORD = 255;
    parameter int RING_AW    = $clog2(RING_BYTES);
    parameter int USED_W     = RING_AW + 1;
    parameter int BYTE_W     = 8;
    parameter int OP_W       = 2;

    // bit positions inside m_tuser
    parameter int OUT_USER_VALID  = 0;
    parameter int OUT_USER_STATUS = 1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_START = 2'd0,
        OP_PUSH_BYTE  = 2'd1,
        OP_POP_BYTE   = 2'd2
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic take_len;       // latch clamped length
        logic wr_data;        // write one record byte
        logic rd_head;        // read length byte at head
        logic rd_cursor;      // read byte at read cursor
        logic evict_step;     // drop oldest record using read length
        logic write_len;      // write length byte and reserve space
        logic pop_setup;      // release oldest record using read length
        logic byte_step;      // present read byte as a result
        logic out_ring_empty; // result: nothing to pop
        logic out_rec_empty;  // result: zero-length record
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic evict_need;
        logic used_zero;
        logic reading;
        logic rlen_zero;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

### design/lprr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lprr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/lprr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lprr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire lprr_pkg::op_t     in_op,
    output logic                   in_ready,
    output lprr_pkg::dp_cmd_t      cmd,
    input  wire lprr_pkg::dp_stat_t stat
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT_CHK,
        ST_EVICT_UPD,
        ST_POP_CHK,
        ST_POP_LEN,
        ST_POP_BYTE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_op)
                        lprr_pkg::OP_PUSH_START:
                        begin
                            cmd.take_len = 1'b1;
                            state_next   = ST_EVICT_CHK;
                        end
                        lprr_pkg::OP_PUSH_BYTE:
                        begin
                            cmd.wr_data = 1'b1;
                        end
                        lprr_pkg::OP_POP_BYTE:
                        begin
                            if (!stat.out_free)
                            begin
                                state_next = ST_POP_CHK;
                            end
                            else if (stat.reading)
                            begin
                                cmd.rd_cursor = 1'b1;
                                state_next    = ST_POP_BYTE;
                            end
                            else if (stat.used_zero)
                            begin
                                cmd.out_ring_empty = 1'b1;
                            end
                            else
                            begin
                                cmd.rd_head = 1'b1;
                                state_next  = ST_POP_LEN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EVICT_CHK:
            begin
                if (stat.evict_need)
                begin
                    cmd.rd_head = 1'b1;
                    state_next  = ST_EVICT_UPD;
                end
                else
                begin
                    cmd.write_len = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_EVICT_UPD:
            begin
                cmd.evict_step = 1'b1;
                state_next     = ST_EVICT_CHK;
            end
            ST_POP_CHK:
            begin
                if (stat.out_free)
                begin
                    if (stat.reading)
                    begin
                        cmd.rd_cursor = 1'b1;
                        state_next    = ST_POP_BYTE;
                    end
                    else if (stat.used_zero)
                    begin
                        cmd.out_ring_empty = 1'b1;
                        state_next         = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rd_head = 1'b1;
                        state_next  = ST_POP_LEN;
                    end
                end
            end
            ST_POP_LEN:
            begin
                cmd.pop_setup = 1'b1;
                if (stat.rlen_zero)
                begin
                    cmd.out_rec_empty = 1'b1;
                    state_next        = ST_IDLE;
                end
                else
                begin
                    state_next = ST_POP_CHK;
                end
            end
            ST_POP_BYTE:
            begin
                cmd.byte_step = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### design/lprr_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module lprr_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lprr_pkg::dp_cmd_t             cmd,
    output lprr_pkg::dp_stat_t                 stat,
    input  wire logic [lprr_pkg::BYTE_W-1:0]   msg_length,
    input  wire logic [lprr_pkg::BYTE_W-1:0]   data_in,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic      [lprr_pkg::BYTE_W-1:0]   m_tdata,
    output logic                               m_tlast,
    output logic      [1:0]                    m_tuser
);

    localparam int AW = lprr_pkg::RING_AW;
    localparam int UW = lprr_pkg::USED_W;
    localparam int BW = lprr_pkg::BYTE_W;

    logic [AW-1:0] head_reg,  head_next;
    logic [UW-1:0] used_reg,  used_next;
    logic [AW-1:0] wcur_reg,  wcur_next;
    logic [BW-1:0] wleft_reg, wleft_next;
    logic [AW-1:0] rcur_reg,  rcur_next;
    logic [BW-1:0] rleft_reg, rleft_next;
    logic          reading_reg, reading_next;
    logic [BW-1:0] len_reg,   len_next;
    logic          out_valid_reg, out_valid_next;
    logic [BW-1:0] out_data_reg,  out_data_next;
    logic          out_last_reg,  out_last_next;
    logic          out_bvalid_reg, out_bvalid_next;
    logic          out_status_reg, out_status_next;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [BW-1:0] ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [BW-1:0] ram_rd_data;

    logic [AW-1:0] tail_addr;
    logic [UW:0]   fill_sum;
    logic [UW-1:0] skip;
    logic [BW-1:0] rleft_dec;

    lprr_ram #(
        .WIDTH (BW),
        .DEPTH (lprr_pkg::RING_BYTES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign tail_addr = head_reg + used_reg[AW-1:0];
    assign fill_sum  = {1'b0, used_reg} + (UW+1)'(len_reg);
    assign skip      = UW'(ram_rd_data) + UW'(1);
    assign rleft_dec = (rleft_reg != '0) ? rleft_reg - BW'(1) : '0;

    assign ram_wr_en   = cmd.write_len | (cmd.wr_data & (wleft_reg != '0));
    assign ram_wr_addr = cmd.write_len ? tail_addr : wcur_reg;
    assign ram_wr_data = cmd.write_len ? len_reg : data_in;
    assign ram_rd_en   = cmd.rd_head | cmd.rd_cursor;
    assign ram_rd_addr = cmd.rd_head ? head_reg : rcur_reg;

    assign stat.evict_need = (used_reg != '0) &&
                             (fill_sum >= (UW+1)'(lprr_pkg::RING_BYTES));
    assign stat.used_zero  = (used_reg == '0);
    assign stat.reading    = reading_reg;
    assign stat.rlen_zero  = (ram_rd_data == '0);
    assign stat.out_free   = !out_valid_reg || m_tready;

    always_comb
    begin
        head_next       = head_reg;
        used_next       = used_reg;
        wcur_next       = wcur_reg;
        wleft_next      = wleft_reg;
        rcur_next       = rcur_reg;
        rleft_next      = rleft_reg;
        reading_next    = reading_reg;
        len_next        = len_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_bvalid_next = out_bvalid_reg;
        out_status_next = out_status_reg;

        if (cmd.take_len)
        begin
            len_next = (msg_length > BW'(lprr_pkg::MAX_RECORD)) ?
                       BW'(lprr_pkg::MAX_RECORD) : msg_length;
        end
        if (cmd.wr_data && (wleft_reg != '0))
        begin
            wcur_next  = wcur_reg + AW'(1);
            wleft_next = wleft_reg - BW'(1);
        end
        if (cmd.evict_step || cmd.pop_setup)
        begin
            head_next = head_reg + skip[AW-1:0];
            used_next = (skip > used_reg) ? '0 : used_reg - skip;
        end
        if (cmd.pop_setup)
        begin
            rcur_next = head_reg + AW'(1);
            if (ram_rd_data != '0)
            begin
                reading_next = 1'b1;
                rleft_next   = ram_rd_data;
            end
        end
        if (cmd.write_len)
        begin
            used_next  = fill_sum[UW-1:0] + UW'(1);
            wcur_next  = tail_addr + AW'(1);
            wleft_next = len_reg;
        end
        if (cmd.byte_step)
        begin
            rcur_next       = rcur_reg + AW'(1);
            rleft_next      = rleft_dec;
            reading_next    = (rleft_dec != '0);
            out_valid_next  = 1'b1;
            out_data_next   = ram_rd_data;
            out_bvalid_next = 1'b1;
            out_last_next   = (rleft_dec == '0);
            out_status_next = 1'b0;
        end
        if (cmd.out_ring_empty || cmd.out_rec_empty)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = '0;
            out_bvalid_next = 1'b0;
            out_last_next   = cmd.out_rec_empty;
            out_status_next = cmd.out_ring_empty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            used_reg      <= '0;
            wcur_reg      <= '0;
            wleft_reg     <= '0;
            rcur_reg      <= '0;
            rleft_reg     <= '0;
            reading_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            used_reg      <= used_next;
            wcur_reg      <= wcur_next;
            wleft_reg     <= wleft_next;
            rcur_reg      <= rcur_next;
            rleft_reg     <= rleft_next;
            reading_reg   <= reading_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg        <= len_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
        out_bvalid_reg <= out_bvalid_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser[lprr_pkg::OUT_USER_VALID]  = out_bvalid_reg;
    assign m_tuser[lprr_pkg::OUT_USER_STATUS] = out_status_reg;

endmodule

`default_nettype wire

### design/length_prefixed_record_ring_core.sv
`timescale 1ns / 1ps
`default_nettype none

// byte ring of lprr_pkg::RING_BYTES entries holding length-prefixed records.
// an input item carries an operation in s_tuser: push_start reserves a record
// (length clamped to MAX_RECORD, oldest records evicted until length+1 bytes
// fit, length byte written), push_byte fills the next reserved byte, pop_byte
// returns one byte of the oldest record and releases it on the first pop.
// only pop_byte gives a result item: data byte in m_tdata, m_tlast on the
// final item of a record (alone, with no byte, for an empty record), and
// m_tuser flags for byte-valid and ring-empty status. the ring storage is a
// single-port-write, registered-read ram that needs no clearing pass after
// reset. steps: push_byte writes its byte directly; push_start does one ram
// read and one pointer update per evicted record, then writes the length
// byte; pop_byte reads a byte inside a record directly, and for the first
// byte of a record reads the length byte at head first, then that byte. a new
// item is taken while a result still waits on m_tready; a pop waits in the
// controller until the output register is free. pops of a record should end
// before the next push_start, as a push may reuse released bytes.
module length_prefixed_record_ring_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // msg_length[7:0], data_in[15:8]
    input  wire logic [1:0]  s_tuser,  // op[1:0]
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,  // data_out[7:0]
    output logic             m_tlast,  // last_byte
    output logic      [1:0]  m_tuser   // byte_valid[0], status[1]
);

    lprr_pkg::dp_cmd_t  cmd;
    lprr_pkg::dp_stat_t stat;
    lprr_pkg::op_t      in_op;

    assign in_op = lprr_pkg::op_t'(s_tuser);

    // sequencing of push, evict and pop steps
    lprr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (in_op),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // pointers, ring ram and output register
    lprr_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .msg_length (s_tdata[7:0]),
        .data_in    (s_tdata[15:8]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

### design/lprr_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module lprr_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast,
    input wire logic [1:0]  m_tuser
);

    // empty-ring item carries nothing else
    a_empty_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == 8'd0) && !m_tuser[0] && !m_tlast)
        else $error("empty-ring item carries data or flags");

    // an item with no byte is either empty ring or empty record
    a_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'd0) && (m_tlast != m_tuser[1]))
        else $error("item without byte is malformed");

    // ready drops only after an item has been taken
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid && s_tready))
        else $error("input ready dropped without an accepted item");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled result item changed");

endmodule

bind length_prefixed_record_ring_core lprr_chk u_chk (.*);

`default_nettype wire
